// ----- hw/rtl/sdrr_pkg.sv -----
// Shared types, constants and the glyph table of the segment rectangle renderer.
package sdrr_pkg;

    localparam int SEGMENT_COUNT = 9;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    // Register indexes on the configuration port (word address bit 2).
    localparam logic REG_DIGIT_WIDTH  = 1'b0;
    localparam logic REG_DIGIT_HEIGHT = 1'b1;

    localparam logic [9:0] WIDTH_MIN    = 10'd4;
    localparam logic [9:0] HEIGHT_MIN   = 10'd3;
    localparam logic [9:0] WIDTH_RESET  = 10'd32;
    localparam logic [9:0] HEIGHT_RESET = 10'd48;

    // Segment numbers.
    localparam logic [3:0] SEG_UPPER_LEFT  = 4'd0;
    localparam logic [3:0] SEG_TOP         = 4'd1;
    localparam logic [3:0] SEG_UPPER_RIGHT = 4'd2;
    localparam logic [3:0] SEG_MIDDLE      = 4'd3;
    localparam logic [3:0] SEG_LOWER_RIGHT = 4'd4;
    localparam logic [3:0] SEG_LOWER_LEFT  = 4'd5;
    localparam logic [3:0] SEG_BOTTOM      = 4'd6;
    localparam logic [3:0] SEG_UPPER_DOT   = 4'd7;
    localparam logic [3:0] SEG_LOWER_DOT   = 4'd8;

    typedef logic [SEGMENT_COUNT-1:0] t_mask;
    typedef logic [10:0]              t_coord;

    typedef struct packed {
        logic [3:0]  new_glyph;
        logic [3:0]  old_glyph;
        logic [11:0] x_offset;
        logic [11:0] y_offset;
    } t_in_item;

    typedef struct packed {
        logic [12:0] rect_left;
        logic [12:0] rect_top;
        logic [12:0] rect_right;
        logic [12:0] rect_bottom;
        logic        lit;
        logic [3:0]  segment_index;
        logic        last;
    } t_out_item;

    // One classified request waiting for the drawing side.
    typedef struct packed {
        t_mask       diff;
        t_mask       new_mask;
        logic [11:0] x_offset;
        logic [11:0] y_offset;
    } t_job;

    // Segment edges inside the cell; right and bottom edges are exclusive.
    typedef struct packed {
        t_coord cb;
        t_coord cc;
        t_coord cd;
        t_coord rf;
        t_coord rg;
        t_coord rh;
        t_coord ri;
        t_coord rj;
        t_coord dk;
        t_coord dl;
        t_coord dm;
        t_coord dn;
        t_coord dq;
        t_coord dp;
    } t_geom;

    function automatic t_mask glyph_mask(input logic [3:0] glyph);
        t_mask m;
        unique case (glyph)
            4'd0:    m = 9'b001110111;
            4'd1:    m = 9'b000010100;
            4'd2:    m = 9'b001101110;
            4'd3:    m = 9'b001011110;
            4'd4:    m = 9'b000011101;
            4'd5:    m = 9'b001011011;
            4'd6:    m = 9'b001111001;
            4'd7:    m = 9'b000010110;
            4'd8:    m = 9'b001111111;
            4'd9:    m = 9'b000011111;
            4'd10:   m = 9'b110000000;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ----- hw/rtl/sdrr_front.sv -----
// Front end: takes requests, looks up both glyph masks and queues changed segments.
module sdrr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sdrr_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output sdrr_pkg::t_job    o_job
);

    logic           r_valid;
    sdrr_pkg::t_job r_job;
    logic           n_valid;
    sdrr_pkg::t_job n_job;
    sdrr_pkg::t_mask new_mask;
    sdrr_pkg::t_mask old_mask;
    logic           accept;

    assign new_mask = sdrr_pkg::glyph_mask(i_item.new_glyph);
    assign old_mask = sdrr_pkg::glyph_mask(i_item.old_glyph);

    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_job   = r_job;

    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            // A request that changes no segment is dropped here.
            n_valid          = (new_mask ^ old_mask) != '0;
            n_job.diff       = new_mask ^ old_mask;
            n_job.new_mask   = new_mask;
            n_job.x_offset   = i_item.x_offset;
            n_job.y_offset   = i_item.y_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

endmodule

// ----- hw/rtl/sdrr_queue.sv -----
// Short request queue between the front end and the drawing side.
module sdrr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sdrr_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sdrr_pkg::t_job o_job
);

    sdrr_pkg::t_job                      r_mem [sdrr_pkg::QUEUE_DEPTH];
    logic [sdrr_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [sdrr_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [sdrr_pkg::QUEUE_CNT_W-1:0]    r_count;
    logic [sdrr_pkg::QUEUE_CNT_W-1:0]    n_count;

    assign o_full  = r_count == sdrr_pkg::QUEUE_CNT_W'(sdrr_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= sdrr_pkg::QUEUE_PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= sdrr_pkg::QUEUE_PTR_W'(r_rd_ptr + 1'b1);
            end
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- hw/rtl/sdrr_geom.sv -----
// Two-stage derivation of the segment edges from the configured cell size.
module sdrr_geom (
    input  logic            i_clk,
    input  logic [9:0]      i_digit_width,
    input  logic [9:0]      i_digit_height,
    output sdrr_pkg::t_geom o_geom
);

    sdrr_pkg::t_coord r_wd;
    sdrr_pkg::t_coord r_ht;
    sdrr_pkg::t_coord r_sw;
    sdrr_pkg::t_coord r_sh;
    sdrr_pkg::t_coord r_sh3;
    sdrr_pkg::t_geom  r_geom;

    logic [9:0]       wd;
    logic [9:0]       ht;
    logic [6:0]       sw;
    logic [5:0]       sh;
    sdrr_pkg::t_coord lu;
    sdrr_pkg::t_coord rg;
    sdrr_pkg::t_coord rh;
    sdrr_pkg::t_coord hs;
    sdrr_pkg::t_coord ws;
    sdrr_pkg::t_coord wm;
    sdrr_pkg::t_coord hm;
    sdrr_pkg::t_coord lm;
    sdrr_pkg::t_geom  n_geom;

    // Stage one: clamp the cell size, then stroke width and height.
    always_comb begin
        wd = (i_digit_width < sdrr_pkg::WIDTH_MIN) ? sdrr_pkg::WIDTH_MIN : i_digit_width;
        ht = (i_digit_height < sdrr_pkg::HEIGHT_MIN) ? sdrr_pkg::HEIGHT_MIN : i_digit_height;
        sw = (wd[9:3] > 7'd2) ? wd[9:3] : 7'd2;
        sh = (ht[9:4] > 6'd1) ? ht[9:4] : 6'd1;
    end

    // Stage two: edges of the bars and the colon dots.
    always_comb begin
        lu = (r_ht - r_sh3) >> 1;
        rg = r_sh + lu;
        rh = rg + r_sh;
        hs = (r_sh + 11'd1) >> 1;
        ws = (r_sw + 11'd1) >> 1;
        wm = (r_wd + 11'd1) >> 1;
        hm = (rh + 11'd1) >> 1;
        lm = (r_ht - rg + 11'd1) >> 1;

        n_geom.cb = r_sw;
        n_geom.cc = r_wd - r_sw;
        n_geom.cd = r_wd;
        n_geom.rf = r_sh;
        n_geom.rg = rg;
        n_geom.rh = rh;
        n_geom.ri = r_ht - r_sh;
        n_geom.rj = r_ht;
        n_geom.dk = wm - ws;
        n_geom.dl = wm + ws;
        n_geom.dm = hm - hs;
        n_geom.dn = hm + hs;
        n_geom.dq = lm - hs + rg;
        n_geom.dp = lm + hs + rg;
    end

    always_ff @(posedge i_clk) begin
        r_wd   <= {1'b0, wd};
        r_ht   <= {1'b0, ht};
        r_sw   <= {4'b0, sw};
        r_sh   <= {5'b0, sh};
        r_sh3  <= {5'b0, sh} + {4'b0, sh, 1'b0};
        r_geom <= n_geom;
    end

    assign o_geom = r_geom;

endmodule

// ----- hw/rtl/sdrr_back.sv -----
// Drawing side: walks the changed segments of one request, one rectangle per cycle while the output is not stalled.
module sdrr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sdrr_pkg::t_geom    i_geom,
    input  logic               i_empty,
    input  sdrr_pkg::t_job     i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output sdrr_pkg::t_out_item o_item
);

    logic                r_busy;
    sdrr_pkg::t_job      r_job;
    logic                r_out_valid;
    sdrr_pkg::t_out_item r_out;

    logic                n_busy;
    sdrr_pkg::t_job      n_job;
    logic                can_load;
    logic                emit;
    logic                last;
    logic [3:0]          seg;
    sdrr_pkg::t_mask     rest;
    sdrr_pkg::t_coord    x0;
    sdrr_pkg::t_coord    y0;
    sdrr_pkg::t_coord    x1;
    sdrr_pkg::t_coord    y1;
    sdrr_pkg::t_out_item n_out;

    // Lowest remaining segment goes first.
    always_comb begin
        seg = '0;
        for (int i = sdrr_pkg::SEGMENT_COUNT - 1; i >= 0; i--) begin
            if (r_job.diff[i]) begin
                seg = 4'(i);
            end
        end
    end

    assign rest     = r_job.diff & (r_job.diff - 1'b1);
    assign last     = rest == '0;
    assign can_load = !r_out_valid || !i_stall;
    assign emit     = r_busy && can_load;
    assign o_pop    = !i_empty && (!r_busy || (emit && last));

    always_comb begin
        unique case (seg)
            sdrr_pkg::SEG_UPPER_LEFT: begin
                x0 = '0;          y0 = i_geom.rf; x1 = i_geom.cb; y1 = i_geom.rg;
            end
            sdrr_pkg::SEG_TOP: begin
                x0 = i_geom.cb;   y0 = '0;        x1 = i_geom.cc; y1 = i_geom.rf;
            end
            sdrr_pkg::SEG_UPPER_RIGHT: begin
                x0 = i_geom.cc;   y0 = i_geom.rf; x1 = i_geom.cd; y1 = i_geom.rg;
            end
            sdrr_pkg::SEG_MIDDLE: begin
                x0 = i_geom.cb;   y0 = i_geom.rg; x1 = i_geom.cc; y1 = i_geom.rh;
            end
            sdrr_pkg::SEG_LOWER_RIGHT: begin
                x0 = i_geom.cc;   y0 = i_geom.rh; x1 = i_geom.cd; y1 = i_geom.ri;
            end
            sdrr_pkg::SEG_LOWER_LEFT: begin
                x0 = '0;          y0 = i_geom.rh; x1 = i_geom.cb; y1 = i_geom.ri;
            end
            sdrr_pkg::SEG_BOTTOM: begin
                x0 = i_geom.cb;   y0 = i_geom.ri; x1 = i_geom.cc; y1 = i_geom.rj;
            end
            sdrr_pkg::SEG_UPPER_DOT: begin
                x0 = i_geom.dk;   y0 = i_geom.dm; x1 = i_geom.dl; y1 = i_geom.dn;
            end
            default: begin
                x0 = i_geom.dk;   y0 = i_geom.dq; x1 = i_geom.dl; y1 = i_geom.dp;
            end
        endcase
    end

    always_comb begin
        // Coordinates wrap at thirteen bits; right and bottom become inclusive.
        n_out.rect_left     = {1'b0, r_job.x_offset} + {2'b0, x0};
        n_out.rect_top      = {1'b0, r_job.y_offset} + {2'b0, y0};
        n_out.rect_right    = {1'b0, r_job.x_offset} + {2'b0, x1} - 13'd1;
        n_out.rect_bottom   = {1'b0, r_job.y_offset} + {2'b0, y1} - 13'd1;
        n_out.lit           = r_job.new_mask[seg];
        n_out.segment_index = seg;
        n_out.last          = last;
    end

    always_comb begin
        n_busy = r_busy;
        n_job  = r_job;
        if (emit) begin
            n_busy     = !last;
            n_job.diff = rest;
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_job  = i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (can_load) begin
                r_out_valid <= r_busy;
            end
        end
        r_job <= n_job;
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ----- hw/rtl/segment_digit_rect_renderer.sv -----
// Top level of the segment rectangle renderer: register port, front end, queue and drawing side.
// A request passes the front-end register, the queue, the drawing-side job register and the output register.
// One rectangle per cycle while the output is not stalled, one for each changed segment of a request
// (one to nine), from the single rectangle generator of the drawing side.
// A request that changes no segment is dropped in the front end and produces nothing.
// Reset clears the pipeline and loads 32 by 48 as the cell size; geometry settles through its registered stages.
module segment_digit_rect_renderer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sdrr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sdrr_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [9:0]      r_digit_width;
    logic [9:0]      r_digit_height;
    logic            cfg_write;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    sdrr_pkg::t_job  front_job;
    sdrr_pkg::t_job  head_job;
    sdrr_pkg::t_geom geom;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == sdrr_pkg::REG_DIGIT_HEIGHT) ? {22'b0, r_digit_height}
                                                                : {22'b0, r_digit_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_width  <= sdrr_pkg::WIDTH_RESET;
            r_digit_height <= sdrr_pkg::HEIGHT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == sdrr_pkg::REG_DIGIT_WIDTH) begin
                r_digit_width <= pwdata[9:0];
            end else begin
                r_digit_height <= pwdata[9:0];
            end
        end
    end

    sdrr_geom u_geom (
        .i_clk          (i_clk),
        .i_digit_width  (r_digit_width),
        .i_digit_height (r_digit_height),
        .o_geom         (geom)
    );

    sdrr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_full  (q_full),
        .o_push  (push),
        .o_job   (front_job)
    );

    sdrr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    sdrr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_empty (q_empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("request pushed into a full queue");

    a_segment_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.segment_index < 4'(sdrr_pkg::SEGMENT_COUNT))
        else $error("segment index out of range");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_item.last) |=> o_out_valid)
        else $error("rectangle burst broken before its last rectangle");

    a_burst_ascends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_item.last)
            |=> o_out_item.segment_index > $past(o_out_item.segment_index))
        else $error("segments of one request not in ascending order");

endmodule
